[sv/wsfd_pkg.sv]
// Package for the WebSocket frame deframer: parse phases, status codes,
// the result record and the 64-bit length range check. No dependencies.
package wsfd_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int HDR_COUNT_W = 4;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD,
    PH_ERR_CONT,
    PH_ERR_LEN
  } phase_t;

  typedef enum logic [2:0] {
    ST_HEADER   = 3'd0,
    ST_PAYLOAD  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_CONT_ERR = 3'd3,
    ST_LEN_ERR  = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
    logic [3:0] opcode;
    logic       last_of_frame;
  } wsfd_result_t;

  // Bits of an extended 64-bit length byte that land below LENGTH_BITS.
  function automatic logic [7:0] ext64_allowed(input logic [2:0] idx);
    logic [7:0] m;
    int         p;
    m = '0;
    p = (7 - int'(idx)) * 8;
    for (int j = 0; j < 8; j++) begin
      if (p + j < LENGTH_BITS) m[j] = 1'b1;
    end
    return m;
  endfunction

endpackage

[sv/wsfd_in_reg.sv]
// Input register of the deframer: holds one raw stream byte until the
// parse stage takes it. Depends on nothing but the clock and reset.
module wsfd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) held_byte <= data_byte;
  end

endmodule

[sv/wsfd_core.sv]
// Parse stage of the deframer: frame state registers and the per-byte
// header, mask-key and payload logic. Uses wsfd_pkg.
module wsfd_core import wsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data_byte,
  output wsfd_result_t result
);

  phase_t                   phase, phase_next;
  logic [HDR_COUNT_W-1:0]   header_count, header_count_next;
  logic [3:0]               frame_opcode, frame_opcode_next;
  logic                     has_mask, has_mask_next;
  logic [31:0]              mask_key, mask_key_next;
  logic [LENGTH_BITS-1:0]   payload_length, payload_length_next;
  logic [LENGTH_BITS-1:0]   payload_count, payload_count_next;

  logic [HDR_COUNT_W-1:0]   hc_inc;
  logic [LENGTH_BITS-1:0]   pc_inc;
  logic [LENGTH_BITS-1:0]   len_shift;
  logic [7:0]               key_byte;
  logic                     finish;
  logic                     finish_mask;

  assign hc_inc    = header_count + HDR_COUNT_W'(1);
  assign pc_inc    = payload_count + LENGTH_BITS'(1);
  assign len_shift = {payload_length[LENGTH_BITS-9:0], data_byte};

  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    frame_opcode_next   = frame_opcode;
    has_mask_next       = has_mask;
    mask_key_next       = mask_key;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    finish              = 1'b0;
    finish_mask         = has_mask;
    result.status        = ST_HEADER;
    result.payload_byte  = 8'h00;
    result.last_of_frame = 1'b0;

    case (phase)
      PH_HDR0: begin
        if (!data_byte[7]) begin
          phase_next    = PH_ERR_CONT;
          result.status = ST_CONT_ERR;
        end else begin
          frame_opcode_next = data_byte[3:0];
          phase_next        = PH_HDR1;
        end
      end
      PH_HDR1: begin
        has_mask_next       = data_byte[7];
        finish_mask         = data_byte[7];
        header_count_next   = '0;
        payload_length_next = '0;
        if (data_byte[6:0] == 7'h7e) begin
          phase_next = PH_EXT16;
        end else if (data_byte[6:0] == 7'h7f) begin
          phase_next = PH_EXT64;
        end else begin
          payload_length_next = LENGTH_BITS'(data_byte[6:0]);
          finish              = 1'b1;
        end
      end
      PH_EXT16: begin
        payload_length_next = len_shift;
        header_count_next   = hc_inc;
        if (hc_inc >= HDR_COUNT_W'(2)) finish = 1'b1;
      end
      PH_EXT64: begin
        if ((data_byte & ~ext64_allowed(header_count[2:0])) != 8'h00) begin
          phase_next    = PH_ERR_LEN;
          result.status = ST_LEN_ERR;
        end else begin
          payload_length_next = len_shift;
          header_count_next   = hc_inc;
          if (hc_inc >= HDR_COUNT_W'(8)) finish = 1'b1;
        end
      end
      PH_MASK: begin
        mask_key_next     = {mask_key[23:0], data_byte};
        header_count_next = hc_inc;
        if (hc_inc >= HDR_COUNT_W'(4)) begin
          header_count_next = '0;
          if (payload_length == '0) begin
            phase_next    = PH_HDR0;
            result.status = ST_EMPTY;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        result.status       = ST_PAYLOAD;
        result.payload_byte = has_mask ? (data_byte ^ key_byte) : data_byte;
        payload_count_next  = pc_inc;
        if (pc_inc == payload_length) begin
          result.last_of_frame = 1'b1;
          payload_count_next   = '0;
          phase_next           = PH_HDR0;
        end
      end
      PH_ERR_CONT: result.status = ST_CONT_ERR;
      PH_ERR_LEN:  result.status = ST_LEN_ERR;
      default: begin
        phase_next    = PH_ERR_LEN;
        result.status = ST_LEN_ERR;
      end
    endcase

    // end of length field: mask key next, payload next, or empty frame
    if (finish) begin
      header_count_next  = '0;
      payload_count_next = '0;
      if (finish_mask) begin
        phase_next = PH_MASK;
      end else if (payload_length_next == '0) begin
        phase_next    = PH_HDR0;
        result.status = ST_EMPTY;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    if (result.status == ST_EMPTY) result.last_of_frame = 1'b1;
    result.opcode = frame_opcode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      header_count   <= '0;
      frame_opcode   <= '0;
      has_mask       <= 1'b0;
      mask_key       <= '0;
      payload_length <= '0;
      payload_count  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      frame_opcode   <= frame_opcode_next;
      has_mask       <= has_mask_next;
      mask_key       <= mask_key_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
    end
  end

endmodule

[sv/wsfd_out_reg.sv]
// Result register of the deframer: holds one result request until the
// receiver takes it. Uses wsfd_pkg for the result record.
module wsfd_out_reg import wsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  wsfd_result_t result,
  output logic         advance,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   status,
  output logic [7:0]   payload_byte,
  output logic [3:0]   opcode,
  output logic         last_of_frame
);

  wsfd_result_t held;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) held <= result;
  end

  assign status        = held.status;
  assign payload_byte  = held.payload_byte;
  assign opcode        = held.opcode;
  assign last_of_frame = held.last_of_frame;

endmodule

[sv/websocket_frame_deframer_unit.sv]
// WebSocket frame deframer, receive side.
// Input channel: one raw stream byte per request on data_byte, with
// in_valid / in_stall. Output channel: exactly one result request per input
// byte (status, payload_byte, opcode, last_of_frame) with out_valid /
// out_stall. Status: header byte, payload byte (unmasked with the frame's
// key if the frame is masked), empty frame done, continuation error or length error.
// A byte accepted into the input register is parsed into the result register,
// where its result is held until the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its request and the
// input register holds the next byte; in_stall rises only while both are
// full. Lengths are limited to LENGTH_BITS bits.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the first header byte; an error locks the parser until reset.
module websocket_frame_deframer_unit import wsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] payload_byte,
  output logic [3:0] opcode,
  output logic       last_of_frame
);

  logic         advance;
  logic         held_valid;
  logic [7:0]   held_byte;
  logic         step;
  wsfd_result_t result;

  assign step = held_valid && advance;

  wsfd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (held_byte),
    .result    (result)
  );

  wsfd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .result        (result),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_byte  (payload_byte),
    .opcode        (opcode),
    .last_of_frame (last_of_frame)
  );

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |->
      (status == ST_PAYLOAD || status == ST_EMPTY))
    else $error("last_of_frame on a non-payload result");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PAYLOAD |-> payload_byte == 8'h00)
    else $error("payload_byte set outside payload result");

  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("parsed byte produced no result");

endmodule
